/* hdl/step_interval_gait_gate_core_macros.svh */
// assertion macros for the step interval gait gate
`ifndef STEP_INTERVAL_GAIT_GATE_CORE_MACROS_SVH
`define STEP_INTERVAL_GAIT_GATE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SIGG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sigg assertion failed");

// next-cycle implication, checked out of reset
`define SIGG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sigg assertion failed");

`endif

/* hdl/sigg_pkg.sv */
// types and constants for the step interval gait gate
package sigg_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_HZ_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_HZ_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CADENCE_FLOOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CV_LIMIT      = 2'd3;

  localparam logic [15:0] RST_STRIDE_HZ_MIN = 16'd205;
  localparam logic [15:0] RST_STRIDE_HZ_MAX = 16'd896;
  localparam logic [15:0] RST_CADENCE_FLOOR = 16'd960;
  localparam logic [15:0] RST_CV_LIMIT      = 16'd8960;

  // 100 percent * 256 (q8) squared is 625 << 20
  localparam logic [9:0] CV_SCALE    = 10'd625;
  localparam int unsigned CV_SHIFT   = 20;
  localparam int unsigned MIN_STAMPS = 3;

  typedef struct packed {
    logic [15:0] step_total;
    logic [31:0] time_ms;
    logic [15:0] cadence_q4;
    logic [15:0] mag_peak_hz;
    logic [15:0] vert_peak_hz;
  } sigg_in_t;

  typedef struct packed {
    logic [19:0] mean_interval_q4;
    logic [15:0] cv_percent_q8;
    logic        walking;
  } sigg_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACC,
    ST_SQ,
    ST_PREP1,
    ST_PREP2,
    ST_ROOT,
    ST_DIV,
    ST_DONE
  } sigg_state_t;

endpackage

/* hdl/step_interval_gait_gate_core.sv */
// step interval gait gate: stamp ring, interval statistics and walking decision
// path: with fewer than three stamps an accepted beat goes from ST_IDLE to ST_DONE,
//   else via ST_FETCH/ST_ACC/ST_SQ over the stamps, ST_PREP1, ST_PREP2, ST_ROOT, ST_DIV, ST_DONE
// throughput: one beat at a time; the next beat is taken once the result is in the
//   output register, which holds it while out_stall is high
// reset: synchronous active-low rst_n clears ring head, fill, prior count, state, out_valid and
//   reloads the register defaults; ring contents are left as they are
module step_interval_gait_gate_core
  import sigg_pkg::*;
#(
  parameter int unsigned WINDOW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sigg_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sigg_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "step_interval_gait_gate_core_macros.svh"

  localparam int unsigned AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NB  = $clog2(WINDOW + 1);
  localparam int unsigned SW  = 16 + NB;
  localparam int unsigned QW  = 32 + NB;
  localparam int unsigned DW  = QW + NB;
  localparam int unsigned PW  = DW + 10;
  localparam int unsigned XW0 = PW + CV_SHIFT;
  localparam int unsigned XW  = XW0 + (XW0 % 2);
  localparam int unsigned RW  = XW / 2;
  localparam int unsigned MW  = SW + 4;
  localparam int unsigned CW  = $clog2(RW + 1);

  logic [15:0] hz_min_r, hz_max_r, cad_floor_r, cv_limit_r;

  logic [31:0] ring [WINDOW];
  logic [31:0] rdata_r;

  sigg_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [NB-1:0] fill_r, fill_nxt;
  logic [15:0]   prior_r, prior_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [NB-1:0] idx_r, idx_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [15:0]   iv_r, iv_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] s2_r, s2_nxt, nq_r, nq_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [RW+1:0] rem_r, rem_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [SW:0]   drem_r, drem_nxt;
  logic [MW-1:0] mnum_r, mnum_nxt;
  logic [NB:0]   mrem_r, mrem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          gate_r, gate_nxt;
  logic          full3_r, full3_nxt;
  logic          cvon_r, cvon_nxt;
  logic          out_valid_r, out_valid_nxt;
  sigg_out_t     out_r, out_nxt;

  logic          in_acc, push;
  logic [NB-1:0] n_w;
  logic [NB:0]   start_w;
  logic [AW-1:0] rptr_inc;
  logic [31:0]   diff_w;
  logic [RW+1:0] remsh_w, trial_w;
  logic [SW:0]   dsh_w;
  logic [NB:0]   msh_w;
  logic [DW-1:0] d_w;
  logic [31:0]   sq_w;
  logic [DW-1:0] s2_w, nq_w;
  logic [PW-1:0] dsc_w;
  logic [15:0]   cv_w;
  logic          band_w;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign push      = in_data.step_total > prior_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign n_w       = fill_r - NB'(1);
  assign rptr_inc  = (rptr_r == AW'(WINDOW - 1)) ? '0 : rptr_r + AW'(1);
  assign diff_w    = rdata_r - prev_r;
  assign remsh_w   = {rem_r[RW-1:0], x_r[XW-1 -: 2]};
  assign trial_w   = {root_r, 2'b01};
  assign dsh_w     = {drem_r[SW-1:0], root_r[RW-1]};
  assign msh_w     = {mrem_r[NB-1:0], mnum_r[MW-1]};
  assign d_w       = nq_r - s2_r;
  assign sq_w      = iv_r * iv_r;
  assign s2_w      = s_r * s_r;
  assign nq_w      = n_w * q_r;
  assign dsc_w     = d_w * CV_SCALE;
  assign cv_w      = (|root_r[RW-1:16]) ? 16'hFFFF : root_r[15:0];
  assign band_w    = (in_data.mag_peak_hz >= hz_min_r && in_data.mag_peak_hz <= hz_max_r) ||
                     (in_data.vert_peak_hz >= hz_min_r && in_data.vert_peak_hz <= hz_max_r);

  // ring storage
  always_ff @(posedge clk) begin
    if (in_acc && push) begin
      ring[head_r] <= in_data.time_ms;
    end
    rdata_r <= ring[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_min_r    <= RST_STRIDE_HZ_MIN;
      hz_max_r    <= RST_STRIDE_HZ_MAX;
      cad_floor_r <= RST_CADENCE_FLOOR;
      cv_limit_r  <= RST_CV_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_STRIDE_HZ_MIN: hz_min_r    <= cfg_data;
        CFG_STRIDE_HZ_MAX: hz_max_r    <= cfg_data;
        CFG_CADENCE_FLOOR: cad_floor_r <= cfg_data;
        CFG_CV_LIMIT:      cv_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      prior_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      prior_r     <= prior_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rptr_r  <= rptr_nxt;
    idx_r   <= idx_nxt;
    prev_r  <= prev_nxt;
    iv_r    <= iv_nxt;
    s_r     <= s_nxt;
    q_r     <= q_nxt;
    s2_r    <= s2_nxt;
    nq_r    <= nq_nxt;
    x_r     <= x_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    drem_r  <= drem_nxt;
    mnum_r  <= mnum_nxt;
    mrem_r  <= mrem_nxt;
    cnt_r   <= cnt_nxt;
    gate_r  <= gate_nxt;
    full3_r <= full3_nxt;
    cvon_r  <= cvon_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    prior_nxt     = prior_r;
    rptr_nxt      = rptr_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    iv_nxt        = iv_r;
    s_nxt         = s_r;
    q_nxt         = q_r;
    s2_nxt        = s2_r;
    nq_nxt        = nq_r;
    x_nxt         = x_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    drem_nxt      = drem_r;
    mnum_nxt      = mnum_r;
    mrem_nxt      = mrem_r;
    cnt_nxt       = cnt_r;
    gate_nxt      = gate_r;
    full3_nxt     = full3_r;
    cvon_nxt      = cvon_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    start_w       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          prior_nxt = in_data.step_total;
          if (push) begin
            head_nxt = (head_r == AW'(WINDOW - 1)) ? '0 : head_r + AW'(1);
            if (fill_r != NB'(WINDOW)) begin
              fill_nxt = fill_r + NB'(1);
            end
          end
          gate_nxt  = (in_data.cadence_q4 >= cad_floor_r) && band_w;
          full3_nxt = fill_nxt >= NB'(MIN_STAMPS);
          start_w   = ({1'b0, NB'(head_nxt)} >= {1'b0, fill_nxt}) ?
                      {1'b0, NB'(head_nxt)} - {1'b0, fill_nxt} :
                      {1'b0, NB'(head_nxt)} + (NB+1)'(WINDOW) - {1'b0, fill_nxt};
          rptr_nxt  = start_w[AW-1:0];
          idx_nxt   = '0;
          s_nxt     = '0;
          q_nxt     = '0;
          state_nxt = (fill_nxt >= NB'(MIN_STAMPS)) ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        prev_nxt = rdata_r;
        if (idx_r == '0) begin
          idx_nxt   = idx_r + NB'(1);
          rptr_nxt  = rptr_inc;
          state_nxt = ST_FETCH;
        end else begin
          iv_nxt    = (|diff_w[31:16]) ? 16'hFFFF : diff_w[15:0];
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        s_nxt    = s_r + SW'(iv_r);
        q_nxt    = q_r + QW'(sq_w);
        idx_nxt  = idx_r + NB'(1);
        rptr_nxt = rptr_inc;
        state_nxt = (idx_r + NB'(1) == fill_r) ? ST_PREP1 : ST_FETCH;
      end
      ST_PREP1: begin
        s2_nxt    = s2_w;
        nq_nxt    = nq_w;
        state_nxt = ST_PREP2;
      end
      ST_PREP2: begin
        x_nxt     = XW'({dsc_w, {CV_SHIFT{1'b0}}});
        rem_nxt   = '0;
        root_nxt  = '0;
        mnum_nxt  = {s_r, 4'b0000};
        mrem_nxt  = '0;
        cnt_nxt   = '0;
        cvon_nxt  = s_r > SW'(n_w);
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        // one result bit of the square root per cycle
        x_nxt = x_r << 2;
        if (remsh_w >= trial_w) begin
          rem_nxt  = remsh_w - trial_w;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = remsh_w;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        // mean divide runs alongside
        if (cnt_r < CW'(MW)) begin
          if (msh_w >= {1'b0, n_w}) begin
            mrem_nxt = msh_w - {1'b0, n_w};
            mnum_nxt = {mnum_r[MW-2:0], 1'b1};
          end else begin
            mrem_nxt = msh_w;
            mnum_nxt = {mnum_r[MW-2:0], 1'b0};
          end
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(RW - 1)) begin
          cnt_nxt   = '0;
          drem_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dsh_w >= {1'b0, s_r}) begin
          drem_nxt = dsh_w - {1'b0, s_r};
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          drem_nxt = dsh_w;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(RW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (full3_r) begin
            out_nxt.mean_interval_q4 = mnum_r[19:0];
            out_nxt.cv_percent_q8    = cvon_r ? cv_w : 16'd0;
            out_nxt.walking          = gate_r && ((cvon_r ? cv_w : 16'd0) < cv_limit_r);
          end else begin
            out_nxt.mean_interval_q4 = '0;
            out_nxt.cv_percent_q8    = '0;
            out_nxt.walking          = 1'b0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SIGG_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= NB'(WINDOW))
  `SIGG_ASSERT_NXT(a_busy_after_beat, in_acc, in_stall)
  `SIGG_ASSERT_IMP(a_walk_cv, out_valid && out_data.walking, out_data.cv_percent_q8 < cv_limit_r)
  `SIGG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

/* tb/sv/tb_step_interval_gait_gate_core.sv */
// testbench for the step interval gait gate: scoreboard prediction with random stalls
module tb_step_interval_gait_gate_core;
  import sigg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 8;

  class gait_scoreboard;
    logic [31:0] stamps[RING];
    int unsigned head, fill;
    logic [15:0] last_total;
    logic [15:0] hz_min, hz_max, cad_floor, cv_lim;
    sigg_out_t pending[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      head = 0;
      fill = 0;
      last_total = 0;
      hz_min = RST_STRIDE_HZ_MIN;
      hz_max = RST_STRIDE_HZ_MAX;
      cad_floor = RST_CADENCE_FLOOR;
      cv_lim = RST_CV_LIMIT;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        CFG_STRIDE_HZ_MIN: hz_min = v;
        CFG_STRIDE_HZ_MAX: hz_max = v;
        CFG_CADENCE_FLOOR: cad_floor = v;
        CFG_CV_LIMIT: cv_lim = v;
        default: ;
      endcase
    endfunction

    function void note_beat(sigg_in_t b);
      sigg_out_t r;
      logic [63:0] n, s, q, d, iv, m;
      logic [31:0] t, prev;
      logic [127:0] lhs, rhs;
      logic [15:0] root;
      logic cv_ok, band_ok;
      r = '0;
      cv_ok = 0;
      if (b.step_total > last_total) begin
        stamps[head] = b.time_ms;
        head = (head + 1) % RING;
        if (fill < RING) fill++;
      end
      last_total = b.step_total;
      if (fill >= 3) begin
        n = fill - 1;
        s = 0;
        q = 0;
        prev = 0;
        for (int i = 0; i < fill; i++) begin
          t = stamps[(head + RING - fill + i) % RING];
          if (i > 0) begin
            iv = {32'd0, t - prev};
            if (iv > 65535) iv = 65535;
            s += iv;
            q += iv * iv;
          end
          prev = t;
        end
        m = (s * 16) / n;
        r.mean_interval_q4 = (m > 64'hFFFFF) ? 20'hFFFFF : m[19:0];
        d = n * q - s * s;
        if (s > n) begin
          if (128'(d) * 10000 >= 128'(s) * s * 65536) r.cv_percent_q8 = 16'hFFFF;
          else begin
            root = 0;
            for (int k = 15; k >= 0; k--) begin
              lhs = 128'(root | (16'd1 << k)) * s;
              lhs = lhs * lhs;
              rhs = 128'(d) * 655360000;
              if (lhs <= rhs) root |= (16'd1 << k);
            end
            r.cv_percent_q8 = root;
          end
        end
        cv_ok = r.cv_percent_q8 < cv_lim;
      end
      band_ok = (b.mag_peak_hz >= hz_min && b.mag_peak_hz <= hz_max) ||
                (b.vert_peak_hz >= hz_min && b.vert_peak_hz <= hz_max);
      r.walking = (b.cadence_q4 >= cad_floor) && band_ok && cv_ok;
      pending.push_back(r);
    endfunction

    function void check_beat(sigg_out_t got);
      sigg_out_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.mean_interval_q4 !== want.mean_interval_q4)
        report($sformatf("mean %0d want %0d", got.mean_interval_q4, want.mean_interval_q4));
      if (got.cv_percent_q8 !== want.cv_percent_q8)
        report($sformatf("cv %0d want %0d", got.cv_percent_q8, want.cv_percent_q8));
      if (got.walking !== want.walking)
        report($sformatf("walking %0b want %0b", got.walking, want.walking));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  sigg_in_t in_data;
  sigg_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gait_scoreboard gait = new();
  int unsigned cycles;
  bit calm;
  logic [15:0] step_count;
  logic [31:0] clock_ms;

  step_interval_gait_gate_core dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) gait.check_beat(out_data);
  end

  initial begin
    int gap;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        out_stall <= 1;
        repeat (gap) @(posedge clk);
        out_stall <= 0;
      end
      @(posedge clk);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    gait.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_beat(sigg_in_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gait.note_beat(b);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (gait.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic sigg_in_t walk_beat(bit steady);
    sigg_in_t b;
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) step_count = step_count - 16'($urandom_range(0, 3));
    else if (r == 1) step_count = 16'($urandom);
    else step_count = step_count + 16'd1;
    if (steady) clock_ms = clock_ms + 32'd500 + 32'($urandom_range(0, 60));
    else clock_ms = clock_ms + ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000));
    b.step_total = step_count;
    b.time_ms = clock_ms;
    b.cadence_q4 = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(800, 2400));
    b.mag_peak_hz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(150, 950));
    b.vert_peak_hz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(150, 950));
    return b;
  endfunction

  initial begin
    sigg_in_t b;
    cycles = 0;
    calm = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_idx = CFG_STRIDE_HZ_MIN;
    cfg_data = 0;
    step_count = 0;
    clock_ms = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: few stamps, extremes, equal/lower counts, wrap, tiny and huge intervals
    b = '{16'd1, 32'hFFFF_FFF0, 16'hFFFF, 16'd205, 16'd0};      send_beat(b);
    b = '{16'd2, 32'h0000_0100, 16'd960, 16'd896, 16'hFFFF};    send_beat(b);
    b = '{16'd2, 32'h0000_0200, 16'd0, 16'd0, 16'd0};           send_beat(b);
    b = '{16'd3, 32'h0000_0300, 16'd960, 16'd897, 16'd204};     send_beat(b);
    b = '{16'd4, 32'h0000_0301, 16'd1200, 16'd500, 16'd500};    send_beat(b);
    b = '{16'd5, 32'h0000_0301, 16'd1200, 16'd500, 16'd500};    send_beat(b);
    b = '{16'd6, 32'h8000_0000, 16'd1200, 16'd500, 16'd500};    send_beat(b);
    b = '{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}; send_beat(b);
    b = '{16'd0, 32'h0, 16'h0, 16'h0, 16'h0};                    send_beat(b);
    for (int i = 1; i <= 9; i++) begin
      b = '{16'(i), 32'(i * 500), 16'd1200, 16'd512, 16'd0};
      send_beat(b);
    end
    for (int i = 10; i <= 13; i++) begin
      b = '{16'(i), 32'(i), 16'd1200, 16'd0, 16'd512};
      send_beat(b);
    end
    drain();
    write_reg(CFG_STRIDE_HZ_MIN, 16'd900);
    write_reg(CFG_STRIDE_HZ_MAX, 16'd100);
    b = '{16'd14, 32'd20, 16'd1200, 16'd500, 16'd500}; send_beat(b);
    step_count = 14;
    clock_ms = 20;

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_STRIDE_HZ_MIN, 16'd205);
          write_reg(CFG_STRIDE_HZ_MAX, 16'd896);
          write_reg(CFG_CADENCE_FLOOR, 16'd960);
          write_reg(CFG_CV_LIMIT, 16'd8960);
        end
        1: begin
          write_reg(CFG_STRIDE_HZ_MIN, 16'd0);
          write_reg(CFG_STRIDE_HZ_MAX, 16'hFFFF);
          write_reg(CFG_CADENCE_FLOOR, 16'd0);
          write_reg(CFG_CV_LIMIT, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_CADENCE_FLOOR, 16'hFFFF);
          write_reg(CFG_CV_LIMIT, 16'd0);
        end
        default: begin
          write_reg(CFG_STRIDE_HZ_MIN, 16'($urandom_range(0, 600)));
          write_reg(CFG_STRIDE_HZ_MAX, 16'($urandom_range(300, 1200)));
          write_reg(CFG_CADENCE_FLOOR, 16'($urandom_range(0, 2000)));
          write_reg(CFG_CV_LIMIT, 16'($urandom));
        end
      endcase
      if (phase == 5) calm = 1;
      for (int i = 0; i < 315; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          b = sigg_in_t'({$urandom, $urandom, $urandom});
          send_beat(b);
        end else send_beat(walk_beat($urandom_range(0, 2) != 0));
      end
    end
    drain();
    if (gait.errors == 0 && gait.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
